/* rtl/core/byte_ring_fifo_with_overwrite_core_defines.svh */
`ifndef BYTE_RING_FIFO_WITH_OVERWRITE_CORE_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_OVERWRITE_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk and held off while rst is high.
`define BRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte ring fifo: same-cycle check failed");

// Next-cycle implication, checked on clk and held off while rst is high.
`define BRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte ring fifo: next-cycle check failed");

`endif

/* rtl/core/brf_pkg.sv */
`default_nettype none

package brf_pkg;

  // Operation codes carried in the action field.
  localparam logic [2:0] ACT_PUT       = 3'd0;
  localparam logic [2:0] ACT_PUT_FORCE = 3'd1;
  localparam logic [2:0] ACT_GET       = 3'd2;
  localparam logic [2:0] ACT_PEEK      = 3'd3;
  localparam logic [2:0] ACT_ADV_WR    = 3'd4;
  localparam logic [2:0] ACT_ADV_RD    = 3'd5;
  localparam logic [2:0] ACT_CLEAR     = 3'd6;

  // Result status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_NO_DATA  = 2'd2;

  // Size register reset value before clamping.
  localparam logic [3:0] SIZE_BITS_RESET = 4'd10;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic [15:0] offset;
    logic        last_of_call;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [1:0] status;
    logic [9:0] data_count;
    logic [9:0] space_count;
    logic       last_of_call_out;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_out;
    logic clr_wr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/brf_ctrl.sv */
`default_nettype none

module brf_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire brf_pkg::stat_t stat,
  output brf_pkg::cmd_t       cmd
);

  import brf_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_FIN
  } state_t;

  state_t state;
  logic   out_free;

  // The result register is free when empty or being emptied this cycle.
  assign out_free = !out_valid || out_ready;

  assign in_ready      = (state == S_IDLE);
  assign cmd.load_item = in_valid && in_ready;
  assign cmd.exec      = (state == S_EXEC);
  assign cmd.load_out  = (state == S_FIN) && out_free;
  assign cmd.clr_wr    = (state == S_CLEAR);

  // Sequencer state and result-valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (stat.clr_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/brf_datapath.sv */
`default_nettype none

module brf_datapath #(
  parameter int MAX_SIZE_BITS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire brf_pkg::cmd_t cmd,
  output brf_pkg::stat_t     stat,
  input  wire brf_pkg::in_t  in_data,
  output brf_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [3:0]    cfg_data
);

  import brf_pkg::*;

  localparam int AW    = MAX_SIZE_BITS;
  localparam int DEPTH = 1 << AW;

  // Size code clamped to the range one up to the maximum.
  function automatic logic [4:0] clamp_bits(input logic [3:0] v);
    logic [4:0] r;
    r = {1'b0, v};
    if (v == 4'd0) begin
      r = 5'd1;
    end else if (r > 5'(MAX_SIZE_BITS)) begin
      r = 5'(MAX_SIZE_BITS);
    end
    return r;
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic [4:0]    size_bits;
  logic [AW:0]   ring_size;
  logic [AW-1:0] mask;
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW-1:0] wp_next;
  logic [AW-1:0] rp_next;
  logic [AW-1:0] count;
  logic [AW-1:0] raddr;
  logic [AW-1:0] off;
  logic [AW-1:0] clr_addr;
  logic          full;
  logic          wr;
  logic          use_rd_next;
  logic          use_rd;
  logic [1:0]    st_next;
  logic [1:0]    st;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  in_t           item;

  // Ring mask from the size code; a full-width ring gives all ones.
  assign ring_size = (AW + 1)'(1) << size_bits;
  assign mask      = AW'(ring_size - (AW + 1)'(1));
  assign count     = (wp - rp) & mask;
  assign full      = (count == mask);
  assign off       = item.offset[AW-1:0];
  assign stat.clr_last = (clr_addr == {AW{1'b1}});

  // Decode of the held item: pointer updates, store access and status.
  always_comb begin
    wp_next     = wp;
    rp_next     = rp;
    raddr       = rp;
    wr          = 1'b0;
    use_rd_next = 1'b0;
    st_next     = STAT_OK;
    unique case (item.action)
      ACT_PUT: begin
        if (full) begin
          st_next = STAT_NO_SPACE;
        end else begin
          wr      = 1'b1;
          wp_next = (wp + 1'b1) & mask;
        end
      end
      ACT_PUT_FORCE: begin
        if (full) begin
          st_next = STAT_NO_SPACE;
          rp_next = (rp + 1'b1) & mask;
        end
        wr      = 1'b1;
        wp_next = (wp + 1'b1) & mask;
      end
      ACT_GET: begin
        if (count == '0) begin
          st_next = STAT_NO_DATA;
        end else begin
          use_rd_next = 1'b1;
          rp_next     = (rp + 1'b1) & mask;
        end
      end
      ACT_PEEK: begin
        raddr = (rp + off) & mask;
        if (32'(item.offset) >= 32'(count)) begin
          st_next = STAT_NO_DATA;
        end else begin
          use_rd_next = 1'b1;
        end
      end
      ACT_ADV_WR: begin
        wp_next = (wp + off) & mask;
      end
      ACT_ADV_RD: begin
        rp_next = (rp + off) & mask;
      end
      ACT_CLEAR: begin
        wp_next = '0;
        rp_next = '0;
      end
      default: begin
      end
    endcase
  end

  // The clearing pass shares the single write port with put operations.
  assign mem_we    = cmd.clr_wr || (cmd.exec && wr);
  assign mem_waddr = cmd.clr_wr ? clr_addr : wp;
  assign mem_wdata = cmd.clr_wr ? 8'd0 : item.data_byte;

  // Size register, pointers and clearing-pass address.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_bits <= clamp_bits(SIZE_BITS_RESET);
      wp        <= '0;
      rp        <= '0;
      clr_addr  <= '0;
    end else begin
      if (cfg_we) begin
        size_bits <= clamp_bits(cfg_data);
        wp        <= '0;
        rp        <= '0;
      end else if (cmd.exec) begin
        wp <= wp_next;
        rp <= rp_next;
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Byte store with one write port and a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.exec) begin
      mem_q <= mem[raddr];
    end
  end

  // Held request and per-request result flags.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.exec) begin
      st     <= st_next;
      use_rd <= use_rd_next;
    end
  end

  // Result register; counts come from the updated pointers.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.read_byte        <= use_rd ? mem_q : 8'd0;
      out_data.status           <= st;
      out_data.data_count       <= 10'(count);
      out_data.space_count      <= 10'(mask - count);
      out_data.last_of_call_out <= item.last_of_call;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/byte_ring_fifo_with_overwrite_core.sv */
`default_nettype none

// Byte ring FIFO with overwrite. Each request is one byte operation (put,
// forced put that drops the oldest byte, get, peek, pointer advance, clear)
// and returns one result with the byte read, a status and the held and free
// counts. After reset the byte store is swept to zero, one entry a cycle,
// over all 2**MAX_SIZE_BITS entries; no request is taken during that sweep,
// while size writes are. Requests are then handled one at a time: capture,
// the store access and pointer update, then loading the result register. A
// pending result does not block taking the next request, which waits to
// load its result until the pending one is drained. Writing the size
// register clears both pointers and must only be done while the block is idle.

module byte_ring_fifo_with_overwrite_core #(
  parameter int MAX_SIZE_BITS = 10
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire brf_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output brf_pkg::out_t     out_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_data
);

  import brf_pkg::*;

  `include "byte_ring_fifo_with_overwrite_core_defines.svh"

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  brf_datapath #(
    .MAX_SIZE_BITS (MAX_SIZE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data)
  );

  // No request is taken while the store is being swept.
  `BRF_ASSERT_IMP(a_no_req_in_sweep, cmd.clr_wr, !in_ready)
  // Only one request is in flight at a time.
  `BRF_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // A pending result is never overwritten.
  `BRF_ASSERT_IMP(a_no_result_overwrite, cmd.load_out, !out_valid || out_ready)

endmodule

`default_nettype wire
